// ===== sv/sps_pkg.sv =====
// Shared constants, register codes and controller/datapath interface types.
`default_nettype none

package sps_pkg;

   localparam int SPS_STACK_DEPTH = 64;
   localparam int SPS_MAX_LENGTH  = 1024;

   localparam int LEN_W      = 11;
   localparam int CAP_W      = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEQUENCE_LENGTH = 1'b0,
      CSR_STACK_CAPACITY  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic set_fail;
      logic pop;
      logic push;
      logic advance;
      logic count_item;
      logic emit;
   } sps_cmd_type;

   typedef struct packed {
      logic failed;
      logic bad;
      logic top_hit;
      logic need_push;
      logic last_push;
      logic last_item;
      logic out_free;
   } sps_status_type;

endpackage

`default_nettype wire

// ===== sv/sps_datapath.sv =====
// Datapath: configuration registers, stack memory, sequence counters and result register.
`default_nettype none

module sps_datapath
   import sps_pkg::*;
#(
   parameter int STACK_DEPTH = SPS_STACK_DEPTH,
   parameter int MAX_LENGTH  = SPS_MAX_LENGTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   input  wire logic [LEN_W-1:0]      req_pop_value,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic                       rsp_sequence_valid,
   input  wire sps_cmd_type           cmd,
   output sps_status_type             status
);

   localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int NUM_W   = LEN_W + 1;
   localparam int ITEM_W  = LEN_W + 1;
   localparam int SUM_W   = ((CNT_W > NUM_W) ? CNT_W : NUM_W) + 1;
   localparam int ENTRY_W = (MAX_LENGTH > (1 << LEN_W)) ? LEN_W :
                            ((MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1);

   logic [LEN_W-1:0]   length_ff, length_in;
   logic [CAP_W-1:0]   capacity_ff, capacity_in;
   logic [LEN_W-1:0]   value_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [NUM_W-1:0]   next_ff, next_in;
   logic [LEN_W-1:0]   items_ff, items_in;
   logic               failed_ff, failed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_data_ff;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ENTRY_W-1:0] stack_mem [STACK_DEPTH];

   logic [LEN_W-1:0]  n_eff;
   logic [SUM_W-1:0]  k_eff;
   logic [SUM_W-1:0]  peak;
   logic [CNT_W-1:0]  count_dec;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              out_of_range;
   logic              top_match;
   logic              buried;
   logic              over_cap;

   always_comb begin
      if (length_ff == '0) begin
         n_eff = LEN_W'(1);
      end else if (int'(length_ff) > MAX_LENGTH) begin
         n_eff = LEN_W'(MAX_LENGTH);
      end else begin
         n_eff = length_ff;
      end
      if (int'(capacity_ff) > STACK_DEPTH) begin
         k_eff = SUM_W'(STACK_DEPTH);
      end else begin
         k_eff = SUM_W'(capacity_ff);
      end
   end

   assign count_dec = count_ff - CNT_W'(1);
   assign rd_addr   = count_dec[ADDR_W-1:0];
   assign wr_addr   = count_ff[ADDR_W-1:0];

   assign out_of_range = (value_ff == '0) || (value_ff > n_eff);
   assign top_match    = (count_ff != '0) && (LEN_W'(rd_data_ff) == value_ff);
   assign buried       = NUM_W'(value_ff) < next_ff;
   assign peak         = SUM_W'(count_ff) + SUM_W'(value_ff) + SUM_W'(1) - SUM_W'(next_ff);
   assign over_cap     = peak > k_eff;

   always_comb begin
      status.failed    = failed_ff;
      status.bad       = out_of_range || (!top_match && (buried || over_cap));
      status.top_hit   = !out_of_range && top_match;
      status.need_push = next_ff < NUM_W'(value_ff);
      status.last_push = (next_ff + NUM_W'(1)) >= NUM_W'(value_ff);
      status.last_item = (ITEM_W'(items_ff) + ITEM_W'(1)) >= ITEM_W'(n_eff);
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      length_in   = length_ff;
      capacity_in = capacity_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEQUENCE_LENGTH: length_in   = csr_write_data[LEN_W-1:0];
            CSR_STACK_CAPACITY:  capacity_in = csr_write_data[CAP_W-1:0];
         endcase
      end

      count_in = count_ff;
      next_in  = next_ff;
      items_in = items_ff;
      failed_in = failed_ff;
      if (cmd.emit) begin
         count_in  = '0;
         next_in   = NUM_W'(1);
         items_in  = '0;
         failed_in = 1'b0;
      end else begin
         if (cmd.pop) begin
            count_in = count_dec;
         end else if (cmd.push) begin
            count_in = count_ff + CNT_W'(1);
         end
         if (cmd.advance) begin
            next_in = NUM_W'(value_ff) + NUM_W'(1);
         end else if (cmd.push) begin
            next_in = next_ff + NUM_W'(1);
         end
         if (cmd.count_item) begin
            items_in = items_ff + LEN_W'(1);
         end
         if (cmd.set_fail) begin
            failed_in = 1'b1;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= LEN_RESET;
         capacity_ff  <= CAP_RESET;
         count_ff     <= '0;
         next_ff      <= NUM_W'(1);
         items_ff     <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         next_ff      <= next_in;
         items_ff     <= items_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         value_ff <= req_pop_value;
      end
      if (cmd.emit) begin
         rsp_data_ff <= !failed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[wr_addr] <= next_ff[ENTRY_W-1:0];
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sequence_valid = rsp_data_ff;

endmodule

`default_nettype wire

// ===== sv/sps_controller.sv =====
// Controller state machine that sequences the check, push and finish steps of each item.
`default_nettype none

module sps_controller
   import sps_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire sps_status_type status,
   output sps_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_PUSH   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_FINISH;
            if (!status.failed) begin
               if (status.bad) begin
                  cmd.set_fail = 1'b1;
               end else if (status.top_hit) begin
                  cmd.pop = 1'b1;
               end else if (status.need_push) begin
                  state_in = ST_PUSH;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            if (status.last_push) begin
               cmd.advance = 1'b1;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.last_item) begin
               cmd.count_item = 1'b1;
               state_in       = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/stack_pop_sequence_checker.sv =====
// Top level of the stack pop sequence checker.
// The block checks whether a stream of values is a legal pop order for the numbers 1..N
// pushed in ascending order onto a stack of at most K entries; N and K come from the
// sequence_length and stack_capacity registers, which the user must write only while
// the block is idle; the block does not enforce this. Each input transfer carries one
// candidate value, and after the N-th transfer one result transfer reports pass (1) or
// fail (0), after which the block is ready for a new sequence. An item goes through
// the check state, the push state once per value pushed (none when the value is on top
// or the sequence has failed) and the finish state before the next item is accepted;
// pushes fill the stack one entry per cycle; a verdict waits until the result is taken.
`default_nettype none

module stack_pop_sequence_checker
   import sps_pkg::*;
#(
   parameter int STACK_DEPTH = SPS_STACK_DEPTH,
   parameter int MAX_LENGTH  = SPS_MAX_LENGTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [LEN_W-1:0]      req_pop_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_sequence_valid
);

   sps_cmd_type    cmd;
   sps_status_type status;

   sps_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sps_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .MAX_LENGTH  (MAX_LENGTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_pop_value      (req_pop_value),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_sequence_valid (rsp_sequence_valid),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

`default_nettype wire

// ===== tb/sv/pop_order_monitor.sv =====
// Monitor that predicts the pop-order verdicts and compares them with the result transfers.
`timescale 1ns / 100ps

module pop_order_monitor
   import sps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [LEN_W-1:0]      req_pop_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_sequence_valid,
   output int                    verdicts_pending,
   output int                    error_count,
   output int                    transfers_checked,
   output int                    legal_verdicts,
   output int                    illegal_verdicts
);

   localparam int ENTRY_W    = 10;
   localparam int ADDR_W     = $clog2(SPS_STACK_DEPTH);
   localparam int REPORT_MAX = 10;

   logic [ENTRY_W-1:0] pushed [SPS_STACK_DEPTH];
   logic [CAP_W-1:0]   depth;
   logic [LEN_W-1:0]   next_push;
   logic [LEN_W-1:0]   seq_items;
   logic               broken;
   logic [LEN_W-1:0]   length_reg;
   logic [CAP_W-1:0]   capacity_reg;
   logic               expected_verdicts [$];
   int                 errors;
   int                 checked;
   int                 legal;
   int                 illegal;

   initial begin
      errors  = 0;
      checked = 0;
      legal   = 0;
      illegal = 0;
   end

   function automatic void clear_sequence();
      depth     = '0;
      next_push = 1;
      seq_items = '0;
      broken    = 1'b0;
   endfunction

   task automatic apply_pop_value(input logic [LEN_W-1:0] value);
      int unsigned      n;
      int unsigned      k;
      logic [CAP_W-1:0] below;
      n = (length_reg == 0) ? 1 :
          (length_reg > SPS_MAX_LENGTH) ? SPS_MAX_LENGTH : length_reg;
      k = (capacity_reg > SPS_STACK_DEPTH) ? SPS_STACK_DEPTH : capacity_reg;
      below = depth - 1'b1;
      if (!broken) begin
         if (value == 0 || value > n) begin
            broken = 1'b1;
         end else if (depth != 0 && LEN_W'(pushed[below[ADDR_W-1:0]]) == value) begin
            depth = depth - 1'b1;
         end else if (value < next_push) begin
            broken = 1'b1;
         end else if (depth + value - next_push + 1 > k) begin
            broken = 1'b1;
         end else begin
            while (next_push < value) begin
               pushed[depth[ADDR_W-1:0]] = next_push[ENTRY_W-1:0];
               depth                     = depth + 1'b1;
               next_push                 = next_push + 1'b1;
            end
            next_push = value + 1'b1;
         end
      end
      seq_items = seq_items + 1'b1;
      if (seq_items >= n) begin
         expected_verdicts.insert(expected_verdicts.size(), !broken);
         clear_sequence();
      end
   endtask

   always @(posedge clock) begin : watch
      logic want;
      if (reset) begin
         length_reg   = LEN_RESET;
         capacity_reg = CAP_RESET;
         clear_sequence();
         expected_verdicts.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               errors++;
               if (errors <= REPORT_MAX) begin
                  $display("Unexpected verdict %0b with none pending at %0t ns.",
                           rsp_sequence_valid, $realtime);
               end
            end else begin
               want = expected_verdicts.pop_front();
               if (want) legal++;
               else illegal++;
               if (rsp_sequence_valid !== want) begin
                  errors++;
                  if (errors <= REPORT_MAX) begin
                     $display("Verdict mismatch at %0t ns: expected %0b, got %0b.",
                              $realtime, want, rsp_sequence_valid);
                  end
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_SEQUENCE_LENGTH: length_reg = csr_write_data;
               CSR_STACK_CAPACITY: capacity_reg = csr_write_data[CAP_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            apply_pop_value(req_pop_value);
            checked++;
         end
      end
      verdicts_pending  <= expected_verdicts.size();
      error_count       <= errors;
      transfers_checked <= checked;
      legal_verdicts    <= legal;
      illegal_verdicts  <= illegal;
   end

endmodule

// ===== tb/sv/stack_pop_sequence_checker_tb.sv =====
// Testbench top that drives pop-order sequences and register settings and gives the verdict.
`timescale 1ns / 100ps

module stack_pop_sequence_checker_tb;
   import sps_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 80;
   localparam int MAX_GAP       = 14;
   localparam int ITEM_TARGET   = 1450;
   localparam int PHASE_ITEMS   = 60;

   typedef enum int {
      ORDER_LEGAL,
      ORDER_OVERFILL,
      ORDER_STRAY,
      ORDER_SWAP,
      ORDER_NOISE
   } order_kind_type;

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  csr_write_enable   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index          = CSR_SEQUENCE_LENGTH;
   logic [CSR_DATA_W-1:0] csr_write_data     = '0;
   logic                  req_valid          = 1'b0;
   logic                  req_ready;
   logic [LEN_W-1:0]      req_pop_value      = '0;
   logic                  rsp_valid;
   logic                  rsp_ready          = 1'b0;
   logic                  rsp_sequence_valid;

   int verdicts_pending;
   int error_count;
   int transfers_checked;
   int legal_verdicts;
   int illegal_verdicts;

   int rsp_wait       = 0;
   bit req_quiet      = 1'b0;
   bit rsp_quiet      = 1'b0;
   int settings_used  = 0;
   int items_sent     = 0;
   int seq_len        = SPS_MAX_LENGTH;
   int stack_cap      = SPS_STACK_DEPTH;
   int pop_order [$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   stack_pop_sequence_checker dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pop_value      (req_pop_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sequence_valid (rsp_sequence_valid)
   );

   pop_order_monitor pop_order_mon (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pop_value      (req_pop_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sequence_valid (rsp_sequence_valid),
      .verdicts_pending   (verdicts_pending),
      .error_count        (error_count),
      .transfers_checked  (transfers_checked),
      .legal_verdicts     (legal_verdicts),
      .illegal_verdicts   (illegal_verdicts)
   );

   // After every transfer the receiver picks a fresh random stall, or none while rsp_quiet is set.
   always @(posedge clock) begin : receiver
      int stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         stall = rsp_quiet ? 0 : $urandom_range(0, MAX_GAP);
         rsp_wait  <= stall;
         rsp_ready <= (stall == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_ready <= (rsp_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_value(input int value);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pop_value <= value[LEN_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_order();
      foreach (pop_order[i]) send_value(pop_order[i]);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input int len_raw, input int cap_raw);
      logic [CSR_DATA_W-1:0] len_bits;
      logic [CSR_DATA_W-1:0] cap_bits;
      len_bits = len_raw[CSR_DATA_W-1:0];
      cap_bits = cap_raw[CSR_DATA_W-1:0];
      settle();
      write_reg(CSR_SEQUENCE_LENGTH, len_bits);
      write_reg(CSR_STACK_CAPACITY, cap_bits);
      seq_len   = (len_bits == 0) ? 1 :
                  (len_bits > SPS_MAX_LENGTH) ? SPS_MAX_LENGTH : len_bits;
      stack_cap = (cap_bits[CAP_W-1:0] > SPS_STACK_DEPTH) ?
                  SPS_STACK_DEPTH : cap_bits[CAP_W-1:0];
      settings_used++;
   endtask

   // Builds a legal pop order of 1..n whose stack never holds more than k entries.
   function automatic void build_order(input int n, input int k, input int pop_pct);
      int held [$];
      int upcoming;
      pop_order.delete();
      upcoming = 1;
      while (pop_order.size() < n) begin
         if (held.size() != 0 &&
             (upcoming > n || held.size() >= k || $urandom_range(0, 99) < pop_pct)) begin
            pop_order.insert(pop_order.size(), held.pop_back());
         end else begin
            held.insert(held.size(), upcoming);
            upcoming++;
         end
      end
   endfunction

   task automatic run_sequence();
      order_kind_type kind;
      int             spot;
      int             other;
      int             held_value;
      kind = ORDER_LEGAL;
      if ($urandom_range(0, 9) >= 6) begin
         kind = order_kind_type'($urandom_range(ORDER_OVERFILL, ORDER_NOISE));
      end
      if (kind == ORDER_OVERFILL) begin
         build_order(seq_len, stack_cap + $urandom_range(1, 4), $urandom_range(10, 90));
      end else begin
         build_order(seq_len, (stack_cap == 0) ? 1 : stack_cap, $urandom_range(10, 90));
      end
      spot  = $urandom_range(0, pop_order.size() - 1);
      other = $urandom_range(0, pop_order.size() - 1);
      case (kind)
         ORDER_STRAY: pop_order[spot] = $urandom_range(0, SPS_MAX_LENGTH);
         ORDER_SWAP: begin
            held_value       = pop_order[spot];
            pop_order[spot]  = pop_order[other];
            pop_order[other] = held_value;
         end
         ORDER_NOISE: begin
            foreach (pop_order[i]) pop_order[i] = $urandom_range(0, SPS_MAX_LENGTH);
         end
         default: ;
      endcase
      req_quiet = ($urandom_range(0, 3) == 0);
      rsp_quiet <= ($urandom_range(0, 3) == 0);
      send_order();
   endtask

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Run stopped after %0d cycles without finishing.", CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int len_raw;
      int cap_raw;
      int carry;
      int phase_items;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // In order, reversed, buried value, zero, and a value above the length.
      apply_setting(3, 3);
      pop_order = '{1, 2, 3, 3, 2, 1, 3, 1, 2, 0, 1, 2, 4, 1, 2};
      send_order();
      apply_setting(3, 1);
      pop_order = '{2, 1, 3};
      send_order();
      apply_setting(1, 0);
      pop_order = '{1};
      send_order();
      apply_setting(1, 1);
      pop_order = '{1, 1024};
      send_order();
      // The length is lowered below the items already seen in an open sequence.
      apply_setting(4, 127);
      pop_order = '{1, 2};
      send_order();
      apply_setting(0, 64);
      pop_order = '{3};
      send_order();

      // One full sequence at the largest length, with the capacity written out of range.
      apply_setting(2047, 1023);
      build_order(seq_len, stack_cap, $urandom_range(30, 70));
      req_quiet = ($urandom_range(0, 1) == 0);
      rsp_quiet <= ($urandom_range(0, 1) == 0);
      send_order();

      carry = 0;
      while (items_sent < ITEM_TARGET) begin
         if (carry != 0) begin
            len_raw = $urandom_range(0, carry + 1);
         end else begin
            case ($urandom_range(0, 5))
               0: len_raw = 1;
               1: len_raw = 2;
               2, 3: len_raw = $urandom_range(3, 12);
               4: len_raw = $urandom_range(13, 40);
               default: len_raw = $urandom_range(0, 6);
            endcase
         end
         case ($urandom_range(0, 5))
            0: cap_raw = 0;
            1: cap_raw = 1;
            2: cap_raw = $urandom_range(2, 8);
            3: cap_raw = $urandom_range(9, 63);
            4: cap_raw = SPS_STACK_DEPTH;
            default: cap_raw = $urandom_range(65, 2047);
         endcase
         apply_setting(len_raw, cap_raw);
         if (carry != 0) begin
            send_value($urandom_range(1, seq_len));
            carry = 0;
         end
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            run_sequence();
            phase_items += seq_len;
         end
         if (seq_len > 1 && $urandom_range(0, 3) == 0) begin
            carry = $urandom_range(1, seq_len - 1);
            build_order(seq_len, (stack_cap == 0) ? 1 : stack_cap, 50);
            for (int i = 0; i < carry; i++) send_value(pop_order[i]);
         end
      end

      settle();
      $display("Checked %0d input transfers and %0d verdicts (%0d legal, %0d illegal).",
               transfers_checked, legal_verdicts + illegal_verdicts, legal_verdicts,
               illegal_verdicts);
      $display("Used %0d register settings, some of them written in mid-sequence.",
               settings_used);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
